// ===== design/linear_to_srgb_pixel_assert.svh =====
// ----------------------------------------------------------------------------
// linear_to_srgb_pixel assertion macros
// Shared property forms for the pixel encoder checker.
// ----------------------------------------------------------------------------
`ifndef LINEAR_TO_SRGB_PIXEL_ASSERT_SVH
`define LINEAR_TO_SRGB_PIXEL_ASSERT_SVH

// condition in one cycle implies a condition in the next, outside reset
`define LSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pixel encoder: next-cycle check failed");

// condition that must hold while reset is asserted
`define LSP_ASSERT_IN_RESET(label, clk, rst_n, cons) \
	label: assert property (@(posedge clk) !(rst_n) |-> (cons)) \
		else $error("pixel encoder: reset state check failed");

`endif

// ===== design/lsp_pkg.sv =====
// ----------------------------------------------------------------------------
// lsp_pkg
// Types, constants and arithmetic helpers of the linear to sRGB pixel encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lsp_pkg;

	// segment table and thresholds
	localparam int SEGMENT_COUNT = 8;
	localparam int SEG_IDX_W = 4;
	localparam logic [31:0] ONE_BITS = 32'h3F80_0000;
	localparam logic [31:0] SMALL_LIMIT = 32'h3B4D_2BE7;
	localparam logic [27:0] SMALL_SCALE_Q16 = 28'd215914906;
	localparam logic [27:0] ALPHA_SCALE_Q16 = 28'd16711680;
	localparam int QUEUE_DEPTH_DEF = 4;

	// colour lanes
	localparam int LANE_RED = 0;
	localparam int LANE_GREEN = 1;
	localparam int LANE_BLUE = 2;

	typedef struct packed {
		logic [31:0] red_bits;
		logic [31:0] green_bits;
		logic [31:0] blue_bits;
		logic [31:0] alpha_bits;
		logic last_in;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] blue_code;
		logic [7:0] green_code;
		logic [7:0] red_code;
		logic [7:0] alpha_code;
		logic last_out;
	} pixel_out_t;

	// classified pixel handed from front to back
	typedef struct packed {
		logic [2:0][31:0] x;
		logic [2:0] lin_sel;
		logic [31:0] alpha_x;
		logic last;
	} lsp_item_t;

	localparam logic signed [31:0] SEG_COEF [0:SEGMENT_COUNT][0:3] = '{
		'{32'sd92698747, -32'sd46017890, 32'sd27976929, -32'sd761472},
		'{32'sd18809648, -32'sd19423568, 32'sd24719485, -32'sd625484},
		'{32'sd6022475, -32'sd10442929, 32'sd22597737, -32'sd456612},
		'{32'sd2880332, -32'sd7006313, 32'sd21339305, -32'sd302287},
		'{32'sd1665119, -32'sd5211858, 32'sd20453795, -32'sd156248},
		'{32'sd1076105, -32'sd4118430, 32'sd19776082, -32'sd15997},
		'{32'sd748553, -32'sd3386516, 32'sd19230306, 32'sd119820},
		'{32'sd548648, -32'sd2864420, 32'sd18775399, 32'sd252054},
		'{32'sd0, 32'sd0, 32'sd0, 32'sd16711680}
	};

	function automatic logic signed [31:0] seg_coef(logic [SEG_IDX_W-1:0] idx, logic [1:0] k);
		logic [SEG_IDX_W-1:0] i;
		i = (idx > SEG_IDX_W'(SEGMENT_COUNT)) ? SEG_IDX_W'(SEGMENT_COUNT) : idx;
		return SEG_COEF[i][k];
	endfunction

	// negatives to zero, above one (also positive nans) to one
	function automatic logic [31:0] clamp_bits(logic [31:0] p);
		logic [31:0] r;
		if (p[31])
			r = '0;
		else if (p > ONE_BITS)
			r = ONE_BITS;
		else
			r = p;
		return r;
	endfunction

	// exact truncating decode of a clamped pattern to q1.31
	function automatic logic [31:0] to_q31(logic [31:0] p);
		logic [7:0] e;
		logic [31:0] m;
		logic [7:0] amt;
		logic [31:0] r;
		e = p[30:23];
		m = {8'd0, (e != 8'd0), p[22:0]};
		if (e == 8'd0)
			e = 8'd1;
		if (e >= 8'd119) begin
			amt = e - 8'd119;
			r = m << amt[3:0];
		end else begin
			amt = 8'd119 - e;
			r = m >> amt;
		end
		return r;
	endfunction

	// linear scale, round half up from q.47, saturate to a byte
	function automatic logic [7:0] lin_code(logic [31:0] x, logic [27:0] scale);
		logic [59:0] prod;
		logic [60:0] sum;
		logic [13:0] v;
		prod = 60'(x) * 60'(scale);
		sum = 61'(prod) + (61'd1 << 46);
		v = sum[60:47];
		return (v > 14'd255) ? 8'd255 : v[7:0];
	endfunction

endpackage

`default_nettype wire

// ===== design/lsp_front.sv =====
// ----------------------------------------------------------------------------
// lsp_front
// Accepts pixels, clamps and decodes each channel, flags the linear segment.
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_front (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  lsp_pkg::pixel_in_t     in_data,
	output logic                   push_valid,
	input  wire                    push_ready,
	output lsp_pkg::lsp_item_t     push_data
);
	import lsp_pkg::*;

	logic       valid_q;
	lsp_item_t  item_q;
	lsp_item_t  item_d;
	logic [2:0][31:0] clamped;

	// decode of the incoming request
	always_comb begin
		clamped[LANE_RED] = clamp_bits(in_data.red_bits);
		clamped[LANE_GREEN] = clamp_bits(in_data.green_bits);
		clamped[LANE_BLUE] = clamp_bits(in_data.blue_bits);
		for (int c = 0; c < 3; c++) begin
			item_d.x[c] = to_q31(clamped[c]);
			item_d.lin_sel[c] = (clamped[c] < SMALL_LIMIT);
		end
		item_d.alpha_x = to_q31(clamp_bits(in_data.alpha_bits));
		item_d.last = in_data.last_in;
	end

	assign in_ready = !valid_q || push_ready;
	assign push_valid = valid_q;
	assign push_data = item_q;

	// holding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= item_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/lsp_queue.sv =====
// ----------------------------------------------------------------------------
// lsp_queue
// Short register queue decoupling the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_queue #(
	parameter int DEPTH = lsp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push_valid,
	output logic                   push_ready,
	input  lsp_pkg::lsp_item_t     push_data,
	output logic                   pop_valid,
	input  wire                    pop_ready,
	output lsp_pkg::lsp_item_t     pop_data
);
	import lsp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	lsp_item_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_data = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

// ===== design/lsp_back.sv =====
// ----------------------------------------------------------------------------
// lsp_back
// Square root pipeline, cubic segment evaluation and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_back (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    pop_valid,
	output logic                   pop_ready,
	input  lsp_pkg::lsp_item_t     pop_data,
	output logic                   out_valid,
	input  wire                    out_ready,
	output lsp_pkg::pixel_out_t    out_data
);
	import lsp_pkg::*;

	localparam int SQ_STAGES = 17;

	typedef struct packed {
		logic [33:0] v;
		logic [19:0] rem;
		logic [16:0] root;
	} sq_t;

	typedef struct packed {
		sq_t [2:0] lane;
		logic [2:0] lin_sel;
		logic [3:0][7:0] lin;
		logic last;
	} sq_item_t;

	typedef struct packed {
		logic [2:0][31:0] acc;
		logic [2:0][16:0] r;
		logic [2:0][SEG_IDX_W-1:0] idx;
		logic [2:0] lin_sel;
		logic [3:0][7:0] lin;
		logic last;
	} hn_item_t;

	logic                  adv;
	sq_item_t              sq_s [SQ_STAGES];
	sq_item_t              sq_d [SQ_STAGES];
	logic [SQ_STAGES-1:0]  sq_vld_s;
	sq_item_t              head;
	hn_item_t              hn_s1, hn_s2, hn_s3;
	hn_item_t              hn_d1, hn_d2, hn_d3;
	logic                  hn_vld_s1, hn_vld_s2, hn_vld_s3;
	logic                  out_valid_q;
	pixel_out_t            out_q;
	pixel_out_t            out_d;

	// one restoring square root step
	function automatic sq_t sq_step(sq_t a);
		sq_t n;
		logic [19:0] rem_sh;
		logic [19:0] trial;
		rem_sh = {a.rem[17:0], a.v[33:32]};
		trial = {1'b0, a.root, 2'b01};
		n.v = a.v << 2;
		if (rem_sh >= trial) begin
			n.rem = rem_sh - trial;
			n.root = {a.root[15:0], 1'b1};
		end else begin
			n.rem = rem_sh;
			n.root = {a.root[15:0], 1'b0};
		end
		return n;
	endfunction

	// one horner step, product rounded in q12.16
	function automatic logic [31:0] hn_step(logic [31:0] acc, logic [16:0] r,
			logic signed [31:0] coef);
		logic signed [49:0] prod;
		logic signed [49:0] rnd;
		logic signed [31:0] sum;
		prod = $signed(acc) * $signed({1'b0, r});
		rnd = (prod + 50'sd32768) >>> 16;
		sum = coef + $signed(rnd[31:0]);
		return sum;
	endfunction

	// final rounding and saturation of a polynomial value
	function automatic logic [7:0] poly_code(logic [31:0] acc);
		logic signed [32:0] f;
		f = ($signed({acc[31], acc}) + 33'sd32768) >>> 16;
		if (f < 0)
			return 8'd0;
		else if (f > 33'sd255)
			return 8'd255;
		else
			return f[7:0];
	endfunction

	assign adv = !out_valid_q || out_ready;
	assign pop_ready = adv;

	// entry: seed the root lanes and apply the linear scales
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			head.lane[c].v = {1'b0, pop_data.x[c], 1'b0};
			head.lane[c].rem = '0;
			head.lane[c].root = '0;
			head.lin[c] = lin_code(pop_data.x[c], SMALL_SCALE_Q16);
		end
		head.lin[3] = lin_code(pop_data.alpha_x, ALPHA_SCALE_Q16);
		head.lin_sel = pop_data.lin_sel;
		head.last = pop_data.last;
	end

	// square root stages, one result bit each
	always_comb begin
		for (int s = 0; s < SQ_STAGES; s++) begin
			sq_d[s] = (s == 0) ? head : sq_s[(s == 0) ? 0 : s - 1];
			for (int c = 0; c < 3; c++)
				sq_d[s].lane[c] = sq_step(sq_d[s].lane[c]);
		end
	end

	// horner stages
	always_comb begin
		hn_d1.lin_sel = sq_s[SQ_STAGES-1].lin_sel;
		hn_d1.lin = sq_s[SQ_STAGES-1].lin;
		hn_d1.last = sq_s[SQ_STAGES-1].last;
		for (int c = 0; c < 3; c++) begin
			hn_d1.r[c] = sq_s[SQ_STAGES-1].lane[c].root;
			hn_d1.idx[c] = hn_d1.r[c][16:13];
			hn_d1.acc[c] = hn_step(seg_coef(hn_d1.idx[c], 2'd0), hn_d1.r[c],
				seg_coef(hn_d1.idx[c], 2'd1));
		end
		hn_d2 = hn_s1;
		hn_d3 = hn_s2;
		for (int c = 0; c < 3; c++) begin
			hn_d2.acc[c] = hn_step(hn_s1.acc[c], hn_s1.r[c], seg_coef(hn_s1.idx[c], 2'd2));
			hn_d3.acc[c] = hn_step(hn_s2.acc[c], hn_s2.r[c], seg_coef(hn_s2.idx[c], 2'd3));
		end
	end

	// result selection in bgra order
	always_comb begin
		logic [2:0][7:0] code;
		for (int c = 0; c < 3; c++)
			code[c] = hn_s3.lin_sel[c] ? hn_s3.lin[c] : poly_code(hn_s3.acc[c]);
		out_d.blue_code = code[LANE_BLUE];
		out_d.green_code = code[LANE_GREEN];
		out_d.red_code = code[LANE_RED];
		out_d.alpha_code = hn_s3.lin[3];
		out_d.last_out = hn_s3.last;
	end

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s <= '0;
			hn_vld_s1 <= 1'b0;
			hn_vld_s2 <= 1'b0;
			hn_vld_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			sq_vld_s <= {sq_vld_s[SQ_STAGES-2:0], pop_valid};
			hn_vld_s1 <= sq_vld_s[SQ_STAGES-1];
			hn_vld_s2 <= hn_vld_s1;
			hn_vld_s3 <= hn_vld_s2;
			out_valid_q <= hn_vld_s3;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int s = 0; s < SQ_STAGES; s++)
				sq_s[s] <= sq_d[s];
			hn_s1 <= hn_d1;
			hn_s2 <= hn_d2;
			hn_s3 <= hn_d3;
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

`default_nettype wire

// ===== design/linear_to_srgb_pixel.sv =====
// ----------------------------------------------------------------------------
// linear_to_srgb_pixel
// Encodes linear float RGBA pixels to 8-bit sRGB codes in BGRA order.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    pixel_in_t (RGBA float bits, last)
// out       output     out_valid / out_ready  pixel_out_t (BGRA codes, last)
//
// Throughput one pixel per clock while the output is not stalled.
// The path runs through the front holding register, the queue, the 17-stage
// square root, three Horner stages and the output register. Reset clears all
// valid state; no clearing pass is needed. A stalled output holds the back
// end; the front keeps taking requests until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_to_srgb_pixel #(
	parameter int QUEUE_DEPTH = lsp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  lsp_pkg::pixel_in_t     in_data,
	output logic                   out_valid,
	input  wire                    out_ready,
	output lsp_pkg::pixel_out_t    out_data
);
	import lsp_pkg::*;

	logic       push_valid, push_ready;
	logic       pop_valid, pop_ready;
	lsp_item_t  push_data, pop_data;

	// clamp and classify
	lsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// decoupling queue
	lsp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// root, segments and rounding
	lsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ===== design/lsp_checker.sv =====
// ----------------------------------------------------------------------------
// lsp_checker
// Port-level checks of the pixel encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "linear_to_srgb_pixel_assert.svh"

module lsp_checker (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	input  wire                    in_ready,
	input  lsp_pkg::pixel_in_t     in_data,
	input  wire                    out_valid,
	input  wire                    out_ready,
	input  lsp_pkg::pixel_out_t    out_data
);
	import lsp_pkg::*;

	// a stalled result stays put
	`LSP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	// a waiting request stays put
	`LSP_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && !in_ready, in_valid && $stable(in_data))
	// no result shows while in reset
	`LSP_ASSERT_IN_RESET(a_rst_out_empty, clk, arst_n, !out_valid)
	// input side is open while in reset
	`LSP_ASSERT_IN_RESET(a_rst_in_open, clk, arst_n, in_ready)

endmodule

bind linear_to_srgb_pixel lsp_checker u_lsp_checker (.*);

`default_nettype wire

// ===== bench/linear_to_srgb_pixel_tb.sv =====
// ----------------------------------------------------------------------------
// linear_to_srgb_pixel_tb
// Streams float RGBA pixels into the encoder, predicts each BGRA code word
// with a fixed-point model of its own, and checks every result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_to_srgb_pixel_tb;
	import lsp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic in_valid = 1'b0;
	logic in_ready;
	pixel_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pixel_out_t out_data;

	pixel_out_t expected_pixels[$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int hold_off_cycles = 0;
	bit rx_idle_enable = 1'b1;
	bit tx_idle_enable = 1'b1;

	linear_to_srgb_pixel u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #4 clk = ~clk;

	// segment coefficients in signed q12.16
	function automatic longint coef_of(int idx, int k);
		longint t [0:8][0:3];
		t = '{
			'{92698747, -46017890, 27976929, -761472},
			'{18809648, -19423568, 24719485, -625484},
			'{6022475, -10442929, 22597737, -456612},
			'{2880332, -7006313, 21339305, -302287},
			'{1665119, -5211858, 20453795, -156248},
			'{1076105, -4118430, 19776082, -15997},
			'{748553, -3386516, 19230306, 119820},
			'{548648, -2864420, 18775399, 252054},
			'{0, 0, 0, 16711680}
		};
		return t[idx][k];
	endfunction

	function automatic logic [31:0] bounded_bits(logic [31:0] p);
		if (p[31])
			return 32'd0;
		if (p > 32'h3F80_0000)
			return 32'h3F80_0000;
		return p;
	endfunction

	function automatic logic [63:0] fixed_q31(logic [31:0] p);
		int e;
		logic [63:0] m;
		e = int'(p[30:23]);
		m = {40'd0, (e != 0), p[22:0]};
		if (e == 0)
			e = 1;
		if (e >= 119)
			return m << (e - 119);
		return m >> (119 - e);
	endfunction

	function automatic longint floor16(longint v);
		return v >>> 16;
	endfunction

	function automatic logic [7:0] byte_sat(longint v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return v[7:0];
	endfunction

	function automatic logic [7:0] scaled_code(logic [63:0] x, logic [63:0] scale);
		logic [63:0] prod;
		prod = x * scale + (64'd1 << 46);
		return byte_sat(longint'(prod >> 47));
	endfunction

	function automatic logic [63:0] root_floor(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	// gamma encode of one colour channel
	function automatic logic [7:0] gamma_code(logic [31:0] raw);
		logic [31:0] p;
		logic [63:0] x;
		logic [63:0] r;
		int idx;
		longint acc;
		p = bounded_bits(raw);
		x = fixed_q31(p);
		if (p < 32'h3B4D_2BE7)
			return scaled_code(x, 64'd215914906);
		r = root_floor(x << 1);
		idx = int'((r * 8) >> 16);
		if (idx > 8)
			idx = 8;
		acc = coef_of(idx, 0);
		for (int k = 1; k < 4; k++)
			acc = coef_of(idx, k) + floor16(acc * longint'(r) + 32768);
		return byte_sat(floor16(acc + 32768));
	endfunction

	function automatic pixel_out_t encoded_pixel(pixel_in_t px);
		pixel_out_t o;
		o.blue_code = gamma_code(px.blue_bits);
		o.green_code = gamma_code(px.green_bits);
		o.red_code = gamma_code(px.red_bits);
		o.alpha_code = scaled_code(fixed_q31(bounded_bits(px.alpha_bits)), 64'd16711680);
		o.last_out = px.last_in;
		return o;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		mismatch_count++;
	endtask

	function automatic int gap_len();
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(5, 30);
		return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
	endfunction

	// send one request and wait for its acceptance; valid drops only in a gap
	task automatic send_pixel(pixel_in_t px);
		int gap;
		gap = tx_idle_enable ? gap_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= px;
		expected_pixels.push_back(encoded_pixel(px));
		do @(posedge clk); while (!in_ready);
	endtask

	// random float patterns, weighted toward the useful range
	function automatic logic [31:0] random_bits();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return {1'b0, 31'($urandom_range(0, 32'h3B4D_2BE7))};
			2: return {9'h07E, 23'($urandom_range(0, 23'h7FFFFF))};
			3: return {1'b0, 8'($urandom_range(100, 126)), 23'($urandom())};
			4: return {1'b1, 31'($urandom())};
			default: return {1'b0, 31'($urandom_range(32'h3B4D_2BE7, 32'h3F80_0000))};
		endcase
	endfunction

	function automatic pixel_in_t random_pixel();
		pixel_in_t px;
		px.red_bits = random_bits();
		px.green_bits = random_bits();
		px.blue_bits = random_bits();
		px.alpha_bits = random_bits();
		px.last_in = ($urandom_range(0, 7) == 0);
		return px;
	endfunction

	function automatic pixel_in_t flat_pixel(logic [31:0] v, logic lst);
		pixel_in_t px;
		px.red_bits = v;
		px.green_bits = v;
		px.blue_bits = v;
		px.alpha_bits = v;
		px.last_in = lst;
		return px;
	endfunction

	// special values on every channel
	task automatic test_directed();
		logic [31:0] vals [20];
		vals = '{32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FC0_0000,
			32'h7F80_0000, 32'h3F80_0000, 32'h3F80_0001, 32'h7F7F_FFFF,
			32'h0000_0001, 32'h007F_FFFF, 32'h3B4D_2BE6, 32'h3B4D_2BE7,
			32'h3F00_0000, 32'h3E80_0000, 32'h3F7F_FFFF, 32'h3A00_0000,
			32'h3C00_0000, 32'hBF80_0000, 32'h7FFF_FFFF, 32'h3D00_0000};
		foreach (vals[i])
			send_pixel(flat_pixel(vals[i], i[0]));
		send_pixel('{32'h3F80_0000, 32'h0, 32'h3B4D_2BE7, 32'hFFFF_FFFF, 1'b1});
		send_pixel('{32'h0, 32'h3F80_0000, 32'h8000_0000, 32'h3F00_0000, 1'b0});
	endtask

	task automatic test_random(int n);
		repeat (n)
			send_pixel(random_pixel());
	endtask

	// back-to-back requests while the receiver holds off
	task automatic test_backpressure();
		tx_idle_enable = 1'b0;
		hold_off_cycles = 80;
		test_random(60);
		tx_idle_enable = 1'b1;
	endtask

	task automatic test_streaming();
		tx_idle_enable = 1'b0;
		rx_idle_enable = 1'b0;
		test_random(300);
		tx_idle_enable = 1'b1;
		rx_idle_enable = 1'b1;
	endtask

	// receiver with random stalls and one long hold-off
	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_ready <= 1'b0;
		end else if (rx_idle_enable)
			out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 20) == 0);
		else
			out_ready <= 1'b1;
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		pixel_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0)
				report("unexpected", 32'(out_data >> 1), 32'd0);
			else begin
				want = expected_pixels.pop_front();
				if (out_data.blue_code !== want.blue_code)
					report("blue_code", 32'(out_data.blue_code), 32'(want.blue_code));
				if (out_data.green_code !== want.green_code)
					report("green_code", 32'(out_data.green_code), 32'(want.green_code));
				if (out_data.red_code !== want.red_code)
					report("red_code", 32'(out_data.red_code), 32'(want.red_code));
				if (out_data.alpha_code !== want.alpha_code)
					report("alpha_code", 32'(out_data.alpha_code), 32'(want.alpha_code));
				if (out_data.last_out !== want.last_out)
					report("last_out", 32'(out_data.last_out), 32'(want.last_out));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("linear_to_srgb_pixel_tb NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(1000);
		test_streaming();
		test_random(270);
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_pixels.size() == 0)
			$display("linear_to_srgb_pixel_tb OK");
		else
			$display("linear_to_srgb_pixel_tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
